FILE: src/text_cell_compositor_with_priority_unit_assert.svh
`ifndef TEXT_CELL_COMPOSITOR_WITH_PRIORITY_UNIT_ASSERT_SVH
`define TEXT_CELL_COMPOSITOR_WITH_PRIORITY_UNIT_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication.
`define TCCP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define TCCP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TCCP_ASSERT_NOW(lbl, ante, cons, msg)
`define TCCP_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

FILE: src/tccp_pkg.sv
package tccp_pkg;

  typedef enum logic [1:0] {
    MODE_CLEAR = 2'd0,
    MODE_DRAW  = 2'd1,
    MODE_READ  = 2'd2
  } mode_e;

  typedef enum logic {
    ST_CLEAR,
    ST_RUN
  } state_e;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 1'b1;

  localparam logic [7:0] WIDTH_RESET  = 8'd80;
  localparam logic [6:0] HEIGHT_RESET = 7'd25;

  localparam logic [7:0]        BLANK_CHAR   = 8'd32;
  localparam logic [7:0]        NEWLINE_CHAR = 8'd10;
  localparam logic signed [15:0] BLANK_ORDER = -16'sd1;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [7:0]         char_code;
    logic [15:0]        color;
    logic signed [15:0] order;
    logic               last_of_text;
    logic [6:0]         read_col;
    logic [5:0]         read_row;
  } in_word_t;

  typedef struct packed {
    logic [7:0]         cell_char;
    logic [15:0]        cell_color;
    logic signed [15:0] cell_order;
  } out_word_t;

  // One stored cell, 40 bits.
  typedef struct packed {
    logic [7:0]         chr;
    logic [15:0]        color;
    logic signed [15:0] order;
  } cell_t;

  localparam cell_t BLANK_CELL = '{chr: BLANK_CHAR, color: 16'h0000, order: BLANK_ORDER};

  // Target classification from the position unit.
  typedef struct packed {
    logic visible;
    logic newline;
  } pos_res_t;

endpackage

FILE: src/tccp_cell_mem.sv
module tccp_cell_mem #(
  parameter int AddrW = 13
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [AddrW-1:0]      waddr_i,
  input  tccp_pkg::cell_t       wdata_i,
  input  logic                  re_i,
  input  logic [AddrW-1:0]      raddr_i,
  output tccp_pkg::cell_t       rdata_o
);

  localparam int Depth = 2 ** AddrW;

  tccp_pkg::cell_t cells_q [Depth];
  tccp_pkg::cell_t rdata_q;

  // Write-first on an address match so a read sees the write of the same cycle.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      cells_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      if (we_i && (waddr_i == raddr_i)) begin
        rdata_q <= wdata_i;
      end else begin
        rdata_q <= cells_q[raddr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/tccp_pos_unit.sv
module tccp_pos_unit #(
  parameter int MaxCols = 128,
  parameter int MaxRows = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         draw_i,
  input  tccp_pkg::in_word_t           word_i,
  input  logic [7:0]                   width_i,
  input  logic [6:0]                   height_i,
  output logic [$clog2(MaxCols)-1:0]   col_o,
  output logic [$clog2(MaxRows)-1:0]   row_o,
  output tccp_pkg::pos_res_t           res_o
);

  localparam int ColW = $clog2(MaxCols);
  localparam int RowW = $clog2(MaxRows);
  localparam logic [8:0] ColLim = 9'(MaxCols);
  localparam logic [8:0] RowLim = 9'(MaxRows);

  logic [15:0] col_off_q, col_off_d;
  logic [15:0] row_off_q, row_off_d;

  logic signed [17:0] x, y;
  logic [8:0] w_ext, h_ext, w_lim, h_lim;
  logic newline;

  assign newline = (word_i.char_code == tccp_pkg::NEWLINE_CHAR);

  assign x = $signed({{2{word_i.pos_x[15]}}, word_i.pos_x}) + $signed({2'b00, col_off_q});
  assign y = $signed({{2{word_i.pos_y[15]}}, word_i.pos_y}) + $signed({2'b00, row_off_q});

  assign w_ext = {1'b0, width_i};
  assign h_ext = {2'b00, height_i};
  assign w_lim = (w_ext > ColLim) ? ColLim : w_ext;
  assign h_lim = (h_ext > RowLim) ? RowLim : h_ext;

  assign res_o.newline = newline;
  assign res_o.visible = !x[17] && (x[16:0] < {8'b0, w_lim}) &&
                         !y[17] && (y[16:0] < {8'b0, h_lim});
  assign col_o = x[ColW-1:0];
  assign row_o = y[RowW-1:0];

  always_comb begin
    col_off_d = col_off_q;
    row_off_d = row_off_q;
    if (draw_i) begin
      if (newline) begin
        row_off_d = row_off_q + 16'd1;
        col_off_d = 16'd0;
      end else begin
        col_off_d = col_off_q + 16'd1;
      end
      if (word_i.last_of_text) begin
        col_off_d = 16'd0;
        row_off_d = 16'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_off_q <= 16'd0;
      row_off_q <= 16'd0;
    end else begin
      col_off_q <= col_off_d;
      row_off_q <= row_off_d;
    end
  end

endmodule

FILE: src/text_cell_compositor_with_priority_unit.sv
// A read word passes through stage 1 into the output register on out_valid_o.
// Throughput: one draw or read word per cycle outside a clear sweep and while no
//   read word is stalled; cell read-modify-write spans the memory read, with
//   write-first forwarding in the cell store. A clear word blocks input while
//   the sweep blanks all cells, one per cycle through the single write port.
// Reset: offsets 0, width 80, height 25, then the same clearing sweep runs.
`include "text_cell_compositor_with_priority_unit_assert.svh"

module text_cell_compositor_with_priority_unit #(
  parameter int MAX_COLS = 128,
  parameter int MAX_ROWS = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration
  input  logic                                cfg_we_i,
  input  logic [tccp_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [tccp_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  // input words
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  tccp_pkg::in_word_t                  in_word_i,
  // result words
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output tccp_pkg::out_word_t                 out_word_o
);

  localparam int ColW  = $clog2(MAX_COLS);
  localparam int RowW  = $clog2(MAX_ROWS);
  localparam int AddrW = ColW + RowW;
  localparam logic [AddrW-1:0] LastAddr = {AddrW{1'b1}};
  localparam logic [8:0] ColLim = 9'(MAX_COLS);
  localparam logic [8:0] RowLim = 9'(MAX_ROWS);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [7:0] width_q;
  logic [6:0] height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= tccp_pkg::WIDTH_RESET;
      height_q <= tccp_pkg::HEIGHT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tccp_pkg::CFG_SCREEN_WIDTH:  width_q  <= cfg_wdata_i;
        tccp_pkg::CFG_SCREEN_HEIGHT: height_q <= cfg_wdata_i[6:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Control: clear sweep FSM
  // ---------------------------------------------------------------------------
  tccp_pkg::state_e state_q, state_d;
  logic [AddrW-1:0] clr_cnt_q, clr_cnt_d;
  logic             clearing;

  logic accept;
  logic is_draw, is_read, is_clear;

  assign is_draw  = (in_word_i.mode == tccp_pkg::MODE_DRAW);
  assign is_read  = (in_word_i.mode == tccp_pkg::MODE_READ);
  assign is_clear = (in_word_i.mode == tccp_pkg::MODE_CLEAR);

  always_comb begin
    state_d   = state_q;
    clr_cnt_d = clr_cnt_q;
    clearing  = 1'b0;
    case (state_q)
      tccp_pkg::ST_CLEAR: begin
        clearing  = 1'b1;
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == LastAddr) begin
          state_d = tccp_pkg::ST_RUN;
        end
      end
      tccp_pkg::ST_RUN: begin
        if (accept && is_clear) begin
          state_d   = tccp_pkg::ST_CLEAR;
          clr_cnt_d = '0;
        end
      end
      default: begin
        state_d = tccp_pkg::ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= tccp_pkg::ST_CLEAR;
      clr_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Address generation
  // ---------------------------------------------------------------------------
  logic [ColW-1:0]    pos_col;
  logic [RowW-1:0]    pos_row;
  tccp_pkg::pos_res_t pos_res;

  tccp_pos_unit #(
    .MaxCols (MAX_COLS),
    .MaxRows (MAX_ROWS)
  ) u_pos (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .draw_i   (accept && is_draw),
    .word_i   (in_word_i),
    .width_i  (width_q),
    .height_i (height_q),
    .col_o    (pos_col),
    .row_o    (pos_row),
    .res_o    (pos_res)
  );

  // Read address: cells beyond the store geometry read as blank.
  logic [8:0]       rd_col_ext, rd_row_ext;
  logic             rd_in_range;
  logic [AddrW-1:0] rd_addr, acc_addr;

  assign rd_col_ext  = {2'b00, in_word_i.read_col};
  assign rd_row_ext  = {3'b000, in_word_i.read_row};
  assign rd_in_range = (rd_col_ext < ColLim) && (rd_row_ext < RowLim);
  assign rd_addr     = {rd_row_ext[RowW-1:0], rd_col_ext[ColW-1:0]};
  assign acc_addr    = is_read ? rd_addr : {pos_row, pos_col};

  // ---------------------------------------------------------------------------
  // Stage 1: word waiting on its cell read
  // ---------------------------------------------------------------------------
  logic                s1_valid_q;
  logic                s1_read_q, s1_wr_q, s1_blank_q;
  logic [AddrW-1:0]    s1_addr_q;
  tccp_pkg::cell_t     s1_cell_q;
  logic                s1_adv;

  logic                out_valid_q;
  tccp_pkg::out_word_t out_word_q;

  tccp_pkg::cell_t     rd_cell;
  logic                draw_we, mem_we;
  logic [AddrW-1:0]    mem_waddr;
  tccp_pkg::cell_t     mem_wdata;

  // A read word holds here while the output register is full and not drained.
  assign s1_adv     = !(s1_read_q && out_valid_q && !out_ready_i);
  assign in_ready_o = (state_q == tccp_pkg::ST_RUN) && (!s1_valid_q || s1_adv);
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_read_q       <= is_read;
      s1_wr_q         <= is_draw && pos_res.visible && !pos_res.newline;
      s1_blank_q      <= !rd_in_range;
      s1_addr_q       <= acc_addr;
      s1_cell_q.chr   <= in_word_i.char_code;
      s1_cell_q.color <= in_word_i.color;
      s1_cell_q.order <= in_word_i.order;
    end
  end

  // Priority test: ties overwrite. The clear sweep owns the write port and
  // supersedes any draw that was still in flight.
  assign draw_we   = s1_valid_q && s1_wr_q &&
                     ($signed(rd_cell.order) <= $signed(s1_cell_q.order));
  assign mem_we    = clearing || draw_we;
  assign mem_waddr = clearing ? clr_cnt_q : s1_addr_q;
  assign mem_wdata = clearing ? tccp_pkg::BLANK_CELL : s1_cell_q;

  tccp_cell_mem #(
    .AddrW (AddrW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (accept),
    .raddr_i (acc_addr),
    .rdata_o (rd_cell)
  );

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  logic out_push;

  assign out_push = s1_valid_q && s1_read_q && s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_push) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_push) begin
      if (s1_blank_q) begin
        out_word_q.cell_char  <= tccp_pkg::BLANK_CHAR;
        out_word_q.cell_color <= 16'h0000;
        out_word_q.cell_order <= tccp_pkg::BLANK_ORDER;
      end else begin
        out_word_q.cell_char  <= rd_cell.chr;
        out_word_q.cell_color <= rd_cell.color;
        out_word_q.cell_order <= rd_cell.order;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `TCCP_ASSERT_NEXT(a_clear_starts, accept && is_clear,
    state_q == tccp_pkg::ST_CLEAR, "clear word did not start the sweep")
  `TCCP_ASSERT_NEXT(a_rdata_held, s1_valid_q && !s1_adv,
    $stable(rd_cell), "cell read data changed while the word was held")
  `TCCP_ASSERT_NOW(a_stall_blocks, s1_valid_q && s1_read_q && out_valid_q && !out_ready_i,
    !in_ready_o, "input taken while a read word was stalled")

endmodule
